// ===== design/dted_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dted_pkg
// Shared types, codes and constants of the elevation record deframer.
// ----------------------------------------------------------------------------
package dted_pkg;

	localparam logic [12:0] MAX_ROWS      = 13'd4096;
	localparam logic [12:0] MAX_COLUMNS   = 13'd4096;
	localparam logic [12:0] ROWS_RESET    = 13'd1201;
	localparam logic [12:0] COLUMNS_RESET = 13'd1201;
	localparam logic [7:0]  SENTINEL_BYTE = 8'd170;
	localparam logic [2:0]  HEADER_LAST   = 3'd7;
	localparam logic [2:0]  FOOTER_LAST   = 3'd3;
	localparam logic signed [15:0] MIN_INIT = 16'sd32767;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_DATA,
		PH_FOOTER,
		PH_DONE,
		PH_HALT
	} phase_t;

	typedef enum logic [1:0] {
		KIND_ELEVATION,
		KIND_COLUMN_END,
		KIND_BAD_SENTINEL,
		KIND_BAD_CHECKSUM
	} kind_t;

	typedef enum logic [1:0] {
		REG_ROWS_PER_COLUMN,
		REG_COLUMN_COUNT,
		REG_VERIFY_CHECKSUM
	} reg_index_t;

	typedef struct packed {
		logic [12:0] rows;
		logic [12:0] cols;
		logic        verify;
	} cfg_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [15:0] elevation;
		logic [11:0]        row_index;
		logic [11:0]        column_index;
		logic signed [15:0] column_min;
		logic [14:0]        column_max;
		logic               last_column;
	} result_t;

	function automatic logic [12:0] clamp_count(input logic [12:0] v, input logic [12:0] hi);
		logic [12:0] r;
		r = v;
		if (v == 13'd0) begin
			r = 13'd1;
		end else if (v > hi) begin
			r = hi;
		end
		return r;
	endfunction

endpackage

// ===== design/dted_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dted_cfg
// Configuration registers with range clamping of the count registers.
// ----------------------------------------------------------------------------
module dted_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [12:0]   cfg_data,
	output dted_pkg::cfg_t cfg
);
	import dted_pkg::*;

	logic [12:0] rows_q;
	logic [12:0] cols_q;
	logic        verify_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q   <= ROWS_RESET;
			cols_q   <= COLUMNS_RESET;
			verify_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROWS_PER_COLUMN: rows_q   <= cfg_data;
				REG_COLUMN_COUNT:    cols_q   <= cfg_data;
				REG_VERIFY_CHECKSUM: verify_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg.rows   = clamp_count(rows_q, MAX_ROWS);
	assign cfg.cols   = clamp_count(cols_q, MAX_COLUMNS);
	assign cfg.verify = verify_q;

endmodule

// ===== design/dted_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dted_parser
// Per-byte record state machine: header, elevations, checksum footer.
// ----------------------------------------------------------------------------
module dted_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  dted_pkg::cfg_t    cfg,
	input  logic              step,
	input  logic [7:0]        stream_byte,
	output logic              emit,
	output dted_pkg::result_t res
);
	import dted_pkg::*;

	phase_t             phase_q, phase_d;
	logic [2:0]         pos_q, pos_d;
	logic [11:0]        row_q, row_d;
	logic [12:0]        col_q, col_d;
	logic [31:0]        sum_q, sum_d;
	logic [23:0]        held_q, held_d;
	logic               sent_ok_q, sent_ok_d;
	logic signed [15:0] min_q, min_d;
	logic signed [15:0] max_q, max_d;

	logic [31:0]        sum_add;
	logic [15:0]        mag16;
	logic signed [15:0] elev;
	logic [12:0]        row_inc;
	logic               rows_done;
	logic [13:0]        col_inc;
	logic               last;
	logic [30:0]        ck_mag;
	logic               match;

	assign sum_add   = sum_q + {24'd0, stream_byte};
	assign mag16     = {1'b0, held_q[6:0], stream_byte};
	assign elev      = held_q[7] ? $signed(16'd0 - mag16) : $signed(mag16);
	assign row_inc   = {1'b0, row_q} + 13'd1;
	assign rows_done = row_inc >= cfg.rows;
	assign col_inc   = {1'b0, col_q} + 14'd1;
	assign last      = col_inc >= {1'b0, cfg.cols};
	assign ck_mag    = {held_q[22:0], stream_byte};
	assign match     = held_q[23] ? (ck_mag == 31'd0 && sum_q == 32'd0)
	                              : ({1'b0, ck_mag} == sum_q);

	// next state
	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		row_d     = row_q;
		col_d     = col_q;
		sum_d     = sum_q;
		held_d    = held_q;
		sent_ok_d = sent_ok_q;
		min_d     = min_q;
		max_d     = max_q;
		if (step) begin
			case (phase_q)
				PH_HEADER: begin
					sum_d = sum_add;
					if (pos_q == 3'd0) begin
						sent_ok_d = (stream_byte == SENTINEL_BYTE);
					end
					if (pos_q != HEADER_LAST) begin
						pos_d = pos_q + 3'd1;
					end else if (!sent_ok_q) begin
						phase_d = PH_HALT;
					end else begin
						phase_d = PH_DATA;
						pos_d   = 3'd0;
						row_d   = 12'd0;
					end
				end
				PH_DATA: begin
					sum_d = sum_add;
					if (pos_q == 3'd0) begin
						held_d = {16'd0, stream_byte};
						pos_d  = 3'd1;
					end else begin
						if (elev < min_q) min_d = elev;
						if (elev > max_q) max_d = elev;
						pos_d = 3'd0;
						row_d = row_inc[11:0];
						if (rows_done) begin
							phase_d = PH_FOOTER;
							held_d  = 24'd0;
						end
					end
				end
				PH_FOOTER: begin
					if (pos_q != FOOTER_LAST) begin
						held_d = {held_q[15:0], stream_byte};
						pos_d  = pos_q + 3'd1;
					end else if (cfg.verify && !match) begin
						phase_d = PH_HALT;
					end else begin
						col_d     = col_inc[12:0];
						phase_d   = last ? PH_DONE : PH_HEADER;
						pos_d     = 3'd0;
						row_d     = 12'd0;
						sum_d     = 32'd0;
						held_d    = 24'd0;
						sent_ok_d = 1'b0;
						min_d     = MIN_INIT;
						max_d     = 16'sd0;
					end
				end
				default: ;
			endcase
		end
	end

	// result
	always_comb begin
		emit             = 1'b0;
		res.kind         = KIND_ELEVATION;
		res.elevation    = 16'sd0;
		res.row_index    = 12'd0;
		res.column_index = col_q[11:0];
		res.column_min   = 16'sd0;
		res.column_max   = 15'd0;
		res.last_column  = 1'b0;
		if (step) begin
			case (phase_q)
				PH_HEADER: begin
					if (pos_q == HEADER_LAST && !sent_ok_q) begin
						emit     = 1'b1;
						res.kind = KIND_BAD_SENTINEL;
					end
				end
				PH_DATA: begin
					if (pos_q != 3'd0) begin
						emit          = 1'b1;
						res.kind      = KIND_ELEVATION;
						res.elevation = elev;
						res.row_index = row_q;
					end
				end
				PH_FOOTER: begin
					if (pos_q == FOOTER_LAST) begin
						emit = 1'b1;
						if (cfg.verify && !match) begin
							res.kind = KIND_BAD_CHECKSUM;
						end else begin
							res.kind        = KIND_COLUMN_END;
							res.column_min  = min_q;
							res.column_max  = max_q[14:0];
							res.last_column = last;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			pos_q     <= 3'd0;
			row_q     <= 12'd0;
			col_q     <= 13'd0;
			sum_q     <= 32'd0;
			held_q    <= 24'd0;
			sent_ok_q <= 1'b0;
			min_q     <= MIN_INIT;
			max_q     <= 16'sd0;
		end else begin
			phase_q   <= phase_d;
			pos_q     <= pos_d;
			row_q     <= row_d;
			col_q     <= col_d;
			sum_q     <= sum_d;
			held_q    <= held_d;
			sent_ok_q <= sent_ok_d;
			min_q     <= min_d;
			max_q     <= max_d;
		end
	end

endmodule

// ===== design/dted_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dted_out_reg
// Result register with valid/ready handshake toward the consumer.
// ----------------------------------------------------------------------------
module dted_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dted_pkg::result_t res_in,
	input  logic              result_ready,
	output logic              result_valid,
	output logic              space,
	output dted_pkg::result_t res_q
);
	import dted_pkg::*;

	logic valid_q;

	assign space        = !valid_q || result_ready;
	assign result_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= res_in;
		end
	end

endmodule

// ===== design/dted_elevation_record_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dted_elevation_record_deframer
// Column record deframer: elevations, column extremes and checksum errors.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle while the input is ready. Each byte is
// decoded in the cycle it is transferred and any result is registered in
// the output register. The input stays ready whenever the output register
// is empty or its result is transferred in the same cycle, so a byte per
// cycle is sustained while the consumer keeps taking results; the single
// output register holds the input back when the consumer stalls. After the
// final column or an error it keeps taking and discarding bytes until reset.
// ----------------------------------------------------------------------------
module dted_elevation_record_deframer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [12:0]        cfg_data,
	input  logic               stream_valid,
	output logic               stream_ready,
	input  logic [7:0]         stream_byte,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [1:0]         kind,
	output logic signed [15:0] elevation,
	output logic [11:0]        row_index,
	output logic [11:0]        column_index,
	output logic signed [15:0] column_min,
	output logic [14:0]        column_max,
	output logic               last_column
);
	import dted_pkg::*;

	cfg_t    cfg;
	logic    step;
	logic    emit;
	result_t res_next;
	result_t res_q;

	assign step = stream_valid && stream_ready;

	dted_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dted_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.step        (step),
		.stream_byte (stream_byte),
		.emit        (emit),
		.res         (res_next)
	);

	dted_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (emit),
		.res_in       (res_next),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.space        (stream_ready),
		.res_q        (res_q)
	);

	assign kind         = res_q.kind;
	assign elevation    = res_q.elevation;
	assign row_index    = res_q.row_index;
	assign column_index = res_q.column_index;
	assign column_min   = res_q.column_min;
	assign column_max   = res_q.column_max;
	assign last_column  = res_q.last_column;

endmodule

// ===== design/dted_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dted_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module dted_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               stream_ready,
	input logic               result_valid,
	input logic               result_ready,
	input logic [1:0]         kind,
	input logic signed [15:0] elevation,
	input logic [11:0]        row_index,
	input logic [11:0]        column_index,
	input logic signed [15:0] column_min,
	input logic [14:0]        column_max,
	input logic               last_column
);
	import dted_pkg::*;

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(kind)
			&& $stable(elevation) && $stable(row_index) && $stable(column_index))
		else $error("stalled result changed");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |-> !stream_ready)
		else $error("input ready while result stalled");

	a_elevation_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_ELEVATION |->
			column_min == 16'sd0 && column_max == 15'd0 && !last_column)
		else $error("column fields set on elevation");

	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (kind == KIND_BAD_SENTINEL || kind == KIND_BAD_CHECKSUM) |->
			elevation == 16'sd0 && row_index == 12'd0 && !last_column)
		else $error("data fields set on error");

endmodule

bind dted_elevation_record_deframer dted_checker u_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the elevation record deframer.
// ----------------------------------------------------------------------------
// Feeds a short hand-checked column record and then a stream of random
// column records. Headers, elevations and checksums are random, and the
// checksum is usually correct. A behavioral deframer in this file predicts
// every result, and each result transfer is compared field by field. The
// register settings are changed between records, and also mid-record. The run
// ends in one of three ways, chosen at random: the final column, a bad
// sentinel or a bad checksum. Trailing bytes after that end must be dropped.
// ----------------------------------------------------------------------------
module tb;
	import dted_pkg::*;

	typedef struct {
		logic [7:0] b;
		bit         typed;
		kind_t      k;
		int         elev;
		int         row;
		int         cmin;
		int         cmax;
	} dir_vec_t;

	logic               clk;
	logic               arst_n       = 1'b0;
	logic               cfg_we       = 1'b0;
	logic [1:0]         cfg_index    = '0;
	logic [12:0]        cfg_data     = '0;
	logic               stream_valid = 1'b0;
	logic               stream_ready;
	logic [7:0]         stream_byte  = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic [1:0]         kind;
	logic signed [15:0] elevation;
	logic [11:0]        row_index;
	logic [11:0]        column_index;
	logic signed [15:0] column_min;
	logic [14:0]        column_max;
	logic               last_column;

	result_t  due_results[$];
	int       mismatches = 0;
	bit       calm = 1'b0;
	dir_vec_t dir_tab[18];

	// register mirror
	logic [12:0] cfg_rows   = ROWS_RESET;
	logic [12:0] cfg_cols   = COLUMNS_RESET;
	logic        cfg_verify = 1'b1;

	// deframer state
	phase_t      ph;
	logic [2:0]  pos;
	int unsigned row_cnt;
	int unsigned col_cnt;
	logic [31:0] run_sum;
	logic [23:0] held;
	logic [7:0]  sentinel;
	int          col_min;
	int          col_max;

	dted_elevation_record_deframer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.stream_valid (stream_valid),
		.stream_ready (stream_ready),
		.stream_byte  (stream_byte),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.kind         (kind),
		.elevation    (elevation),
		.row_index    (row_index),
		.column_index (column_index),
		.column_min   (column_min),
		.column_max   (column_max),
		.last_column  (last_column)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic void open_column();
		ph       = PH_HEADER;
		pos      = '0;
		row_cnt  = 0;
		run_sum  = '0;
		held     = '0;
		sentinel = '0;
		col_min  = 32767;
		col_max  = 0;
	endfunction

	function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
		int unsigned rows;
		int unsigned cols;
		int unsigned mag;
		int          h;
		bit          match;
		bit          last;
		rows = (cfg_rows == 0) ? 1 : (cfg_rows > MAX_ROWS) ? MAX_ROWS : cfg_rows;
		cols = (cfg_cols == 0) ? 1 : (cfg_cols > MAX_COLUMNS) ? MAX_COLUMNS : cfg_cols;
		r = '0;
		r.column_index = col_cnt[11:0];
		case (ph)
			PH_HEADER: begin
				run_sum += b;
				if (pos == 0)
					sentinel = b;
				if (pos < HEADER_LAST) begin
					pos++;
					return 1'b0;
				end
				if (sentinel != SENTINEL_BYTE) begin
					ph = PH_HALT;
					r.kind = KIND_BAD_SENTINEL;
					return 1'b1;
				end
				ph = PH_DATA;
				pos = '0;
				row_cnt = 0;
				return 1'b0;
			end
			PH_DATA: begin
				run_sum += b;
				if (pos == 0) begin
					held = {16'd0, b};
					pos = 3'd1;
					return 1'b0;
				end
				mag = {17'd0, held[6:0], b};
				h = held[7] ? -int'(mag) : int'(mag);
				if (h < col_min)
					col_min = h;
				if (h > col_max)
					col_max = h;
				r.kind      = KIND_ELEVATION;
				r.elevation = h[15:0];
				r.row_index = row_cnt[11:0];
				pos = '0;
				row_cnt++;
				if (row_cnt >= rows) begin
					ph = PH_FOOTER;
					held = '0;
				end
				return 1'b1;
			end
			PH_FOOTER: begin
				if (pos < FOOTER_LAST) begin
					held = {held[15:0], b};
					pos++;
					return 1'b0;
				end
				mag = {1'b0, held[22:0], b};
				// sign-magnitude checksum: negative only matches as zero on a zero sum
				if (held[23])
					match = (mag == 0) && (run_sum == 0);
				else
					match = (mag == run_sum);
				if (cfg_verify && !match) begin
					ph = PH_HALT;
					r.kind = KIND_BAD_CHECKSUM;
					return 1'b1;
				end
				last = (col_cnt + 1 >= cols);
				r.kind        = KIND_COLUMN_END;
				r.column_min  = col_min[15:0];
				r.column_max  = col_max[14:0];
				r.last_column = last;
				col_cnt++;
				open_column();
				if (last)
					ph = PH_DONE;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic push_byte(input logic [7:0] b, input bit typed = 1'b0,
			input result_t want = '0);
		result_t r;
		bit      got;
		while (!calm && $urandom_range(99) < 26) begin
			stream_valid <= 1'b0;
			@(posedge clk);
		end
		stream_valid <= 1'b1;
		stream_byte  <= b;
		@(posedge clk);
		while (!stream_ready)
			@(posedge clk);
		got = deframe_byte(b, r);
		if (typed)
			due_results.push_back(want);
		else if (got)
			due_results.push_back(r);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [12:0] v);
		stream_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ROWS_PER_COLUMN: cfg_rows = v;
			REG_COLUMN_COUNT:    cfg_cols = v;
			default:             cfg_verify = v[0];
		endcase
	endtask

	task automatic send_column(input logic [7:0] lead, input bit corrupt, input bit cut_ok);
		logic [7:0]  hi;
		logic [7:0]  lo;
		logic [31:0] ck;
		int          signmode;
		signmode = $urandom_range(2);
		push_byte(lead);
		repeat (7) push_byte(8'($urandom));
		while (ph == PH_DATA) begin
			// shrink the row count to at most the rows already seen
			if (cut_ok && row_cnt > 0 && ($urandom_range(59) == 0 || row_cnt >= 8))
				write_reg(REG_ROWS_PER_COLUMN, 13'($urandom_range(row_cnt)));
			hi = 8'($urandom);
			lo = 8'($urandom);
			if (signmode == 1)
				hi[7] = 1'b0;
			else if (signmode == 2)
				hi[7] = 1'b1;
			case ($urandom_range(11))
				0: {hi, lo} = 16'h7FFF;
				1: {hi, lo} = 16'hFFFF;
				2: {hi, lo} = 16'h8000;
				3: {hi, lo} = 16'h0000;
				default: ;
			endcase
			push_byte(hi);
			push_byte(lo);
		end
		if (ph != PH_FOOTER)
			return;
		if (corrupt)
			ck = $urandom_range(1) ? (run_sum ^ (32'd1 << $urandom_range(30)))
				: (run_sum | 32'h8000_0000);
		else if (cfg_verify)
			ck = run_sum;
		else begin
			case ($urandom_range(3))
				0: ck = run_sum;
				1: ck = $urandom;
				2: ck = 32'h8000_0000;
				default: ck = run_sum | 32'h8000_0000;
			endcase
		end
		for (int k = 3; k >= 0; k--)
			push_byte(ck[8*k +: 8]);
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		result_ready <= calm || ($urandom_range(99) >= 26);
		if (result_valid && result_ready) begin
			if (due_results.size() == 0) begin
				$error("result transfer with nothing expected, kind %0d", kind);
				mismatches++;
			end else begin
				want = due_results.pop_front();
				if (kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, kind);
					mismatches++;
				end
				if (elevation !== want.elevation) begin
					$error("elevation: expected %0d, got %0d", want.elevation, elevation);
					mismatches++;
				end
				if (row_index !== want.row_index) begin
					$error("row_index: expected %0d, got %0d", want.row_index, row_index);
					mismatches++;
				end
				if (column_index !== want.column_index) begin
					$error("column_index: expected %0d, got %0d", want.column_index,
						column_index);
					mismatches++;
				end
				if (column_min !== want.column_min) begin
					$error("column_min: expected %0d, got %0d", want.column_min, column_min);
					mismatches++;
				end
				if (column_max !== want.column_max) begin
					$error("column_max: expected %0d, got %0d", want.column_max, column_max);
					mismatches++;
				end
				if (last_column !== want.last_column) begin
					$error("last_column: expected %0d, got %0d", want.last_column,
						last_column);
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		result_t    want;
		logic [7:0] lead;
		// one three-row column: both elevation extremes and negative zero
		dir_tab = '{
			'{SENTINEL_BYTE, 1'b0, KIND_ELEVATION, 0, 0, 0, 0},
			'{8'hFF, 1'b0, KIND_ELEVATION, 0, 0, 0, 0},
			'{8'h00, 1'b0, KIND_ELEVATION, 0, 0, 0, 0},
			'{8'h00, 1'b0, KIND_ELEVATION, 0, 0, 0, 0},
			'{8'h00, 1'b0, KIND_ELEVATION, 0, 0, 0, 0},
			'{8'h00, 1'b0, KIND_ELEVATION, 0, 0, 0, 0},
			'{8'h00, 1'b0, KIND_ELEVATION, 0, 0, 0, 0},
			'{8'h00, 1'b0, KIND_ELEVATION, 0, 0, 0, 0},
			'{8'h7F, 1'b0, KIND_ELEVATION, 0, 0, 0, 0},
			'{8'hFF, 1'b1, KIND_ELEVATION, 32767, 0, 0, 0},
			'{8'hFF, 1'b0, KIND_ELEVATION, 0, 0, 0, 0},
			'{8'hFF, 1'b1, KIND_ELEVATION, -32767, 1, 0, 0},
			'{8'h80, 1'b0, KIND_ELEVATION, 0, 0, 0, 0},
			'{8'h00, 1'b1, KIND_ELEVATION, 0, 2, 0, 0},
			'{8'h00, 1'b0, KIND_ELEVATION, 0, 0, 0, 0},
			'{8'h00, 1'b0, KIND_ELEVATION, 0, 0, 0, 0},
			'{8'h05, 1'b0, KIND_ELEVATION, 0, 0, 0, 0},
			'{8'hA5, 1'b1, KIND_COLUMN_END, 0, 0, -32767, 32767}
		};
		col_cnt = 0;
		open_column();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_ROWS_PER_COLUMN, 13'd3);
		foreach (dir_tab[i]) begin
			want = '0;
			want.kind       = dir_tab[i].k;
			want.elevation  = 16'(dir_tab[i].elev);
			want.row_index  = 12'(dir_tab[i].row);
			want.column_min = 16'(dir_tab[i].cmin);
			want.column_max = 15'(dir_tab[i].cmax);
			push_byte(dir_tab[i].b, dir_tab[i].typed, want);
		end

		write_reg(REG_COLUMN_COUNT, 13'h1FFF);
		for (int n = 0; n < 30; n++) begin
			calm = (n >= 14 && n < 20);
			if (n == 5)
				write_reg(REG_COLUMN_COUNT, MAX_COLUMNS);
			else if ($urandom_range(9) == 0)
				write_reg(REG_COLUMN_COUNT, 13'($urandom_range(200, 8191)));
			if (n == 8)
				write_reg(REG_ROWS_PER_COLUMN, MAX_ROWS);
			else if (n == 9)
				write_reg(REG_ROWS_PER_COLUMN, 13'h1FFF);
			else if (n == 10 || $urandom_range(2) == 0)
				write_reg(REG_ROWS_PER_COLUMN, 13'($urandom_range(6)));
			if (n == 3 || $urandom_range(4) == 0)
				write_reg(REG_VERIFY_CHECKSUM, (n == 3) ? 13'd0 : 13'($urandom));
			send_column(SENTINEL_BYTE, 1'b0, 1'b1);
		end
		calm = 1'b0;

		case ($urandom_range(2))
			0: begin
				write_reg(REG_COLUMN_COUNT, 13'($urandom_range(1)));
				send_column(SENTINEL_BYTE, 1'b0, 1'b0);
			end
			1: begin
				lead = 8'($urandom);
				if (lead == SENTINEL_BYTE)
					lead = 8'h55;
				send_column(lead, 1'b0, 1'b0);
			end
			default: begin
				write_reg(REG_VERIFY_CHECKSUM, 13'd1);
				send_column(SENTINEL_BYTE, 1'b1, 1'b0);
			end
		endcase
		// the block is stopped now and drops whatever follows
		repeat (20) push_byte(8'($urandom));
		stream_valid <= 1'b0;

		while (due_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== dted_elevation_record_deframer.f =====
design/dted_pkg.sv
design/dted_cfg.sv
design/dted_parser.sv
design/dted_out_reg.sv
design/dted_elevation_record_deframer.sv
design/dted_checker.sv
tb/tb.sv
